// ----- design/protobuf_wire_field_tokenizer_top_assert.svh -----
// Assertion macros used by the tokenizer decoder.
// Expands to concurrent assertions in simulation and to nothing in synthesis.
`ifndef PROTOBUF_WIRE_FIELD_TOKENIZER_TOP_ASSERT_SVH
`define PROTOBUF_WIRE_FIELD_TOKENIZER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define PBT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("pbt assertion failed");
`define PBT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pbt forbidden condition seen");
`else
`define PBT_ASSERT(lbl, clk, rstn, prop)
`define PBT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- design/pbt_pkg.sv -----
// Shared types and constants of the protobuf wire field tokenizer.
// No dependencies; the stage, decoder and top modules import this package.
package pbt_pkg;

  localparam int unsigned MAX_VARINT_BYTES = 10;

  // Wire type codes of a tag
  localparam logic [2:0] WIRE_VARINT  = 3'd0;
  localparam logic [2:0] WIRE_FIXED64 = 3'd1;
  localparam logic [2:0] WIRE_LEN     = 3'd2;
  localparam logic [2:0] WIRE_SGROUP  = 3'd3;
  localparam logic [2:0] WIRE_EGROUP  = 3'd4;
  localparam logic [2:0] WIRE_FIXED32 = 3'd5;
  localparam logic [2:0] WIRE_RSVD6   = 3'd6;
  localparam logic [2:0] WIRE_RSVD7   = 3'd7;

  typedef enum logic [2:0] {
    PH_TAG     = 3'd0,
    PH_VARVAL  = 3'd1,
    PH_FIXED   = 3'd2,
    PH_LENLEN  = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_ERR     = 3'd5
  } pbt_phase_e;

  typedef enum logic [1:0] {
    KIND_FIELD   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2,
    KIND_END     = 2'd3
  } pbt_kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_TOO_LONG  = 2'd1,
    CAUSE_BAD_WIRE  = 2'd2,
    CAUSE_TRUNCATED = 2'd3
  } pbt_cause_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } pbt_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] field_id;
    logic [2:0]  wire_code;
    logic [63:0] field_value;
    logic [7:0]  payload_byte;
    logic [1:0]  error_cause;
    logic        msg_end;
  } pbt_result_t;

endpackage

// ----- design/pbt_in_if.sv -----
// Input byte channel: valid/ready handshake with the raw byte and end flag.
// No dependencies.
interface pbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// ----- design/pbt_out_if.sv -----
// Result channel: valid/ready handshake with one decoded token.
// No dependencies.
interface pbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] field_id;
  logic [2:0]  wire_code;
  logic [63:0] field_value;
  logic [7:0]  payload_byte;
  logic [1:0]  error_cause;
  logic        msg_end;

  modport source (output valid, output kind, output field_id, output wire_code,
                  output field_value, output payload_byte, output error_cause,
                  output msg_end, input ready);
  modport sink   (input valid, input kind, input field_id, input wire_code,
                  input field_value, input payload_byte, input error_cause,
                  input msg_end, output ready);
endinterface

// ----- design/pbt_in_stage.sv -----
// Input register of the tokenizer: holds one byte until the decoder takes it.
// Depends on pbt_pkg.
module pbt_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  pbt_pkg::pbt_item_t item_i,
  output logic              valid_o,
  output pbt_pkg::pbt_item_t item_o,
  input  logic              take_i
);
  import pbt_pkg::*;

  logic      valid_q, valid_d;
  pbt_item_t item_q;

  // refill in the same cycle the held byte is consumed
  assign ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (take_i) begin
      valid_d = 1'b0;
    end
    if (valid_i && ready_o) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- design/pbt_decode.sv -----
// Wire-format decoder core: parse state registers and the per-byte step logic.
// Depends on pbt_pkg and the assertion macro header.
`include "protobuf_wire_field_tokenizer_top_assert.svh"

module pbt_decode #(
  parameter int unsigned MaxVarintBytes = pbt_pkg::MAX_VARINT_BYTES
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_valid_i,
  input  pbt_pkg::pbt_item_t   item_i,
  input  logic                 out_free_i,
  output logic                 take_o,
  output logic                 emit_o,
  output pbt_pkg::pbt_result_t result_o
);
  import pbt_pkg::*;

  localparam int unsigned CntW = $clog2(MaxVarintBytes + 1);

  pbt_phase_e     phase_q, phase_d;
  logic [63:0]    acc_q, acc_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [31:0]    field_q, field_d;
  logic [2:0]     wire_q, wire_d;
  logic [63:0]    rem_q, rem_d;

  logic [63:0]    vacc, facc, rem_dec;
  logic [CntW-1:0] vcnt;
  logic [31:0]    tag_field;
  logic [2:0]     tag_wire;
  logic           tag_known, more, too_long, rem_last, bad_wire;
  logic           emit;
  pbt_result_t    res;
  logic           last_take, parse_idle, err_emit;

  // OR seven value bits into the lane picked by the byte count
  function automatic logic [63:0] varint_merge(logic [63:0] acc, logic [CntW-1:0] cnt,
                                               logic [6:0] bits);
    logic [63:0] r;
    r = acc;
    for (int i = 0; i < MaxVarintBytes; i++) begin
      if (cnt == CntW'(i)) begin
        r = r | (64'(bits) << (7 * i));
      end
    end
    return r;
  endfunction

  assign take_o    = item_valid_i && out_free_i;
  assign vacc      = varint_merge(acc_q, cnt_q, item_i.in_byte[6:0]);
  assign vcnt      = cnt_q + CntW'(1);
  assign facc      = acc_q | (64'(item_i.in_byte) << {cnt_q[2:0], 3'b000});
  assign rem_dec   = rem_q - 64'd1;
  assign rem_last  = (rem_q == 64'd1);
  assign tag_field = vacc[34:3];
  assign tag_wire  = vacc[2:0];
  assign tag_known = (phase_q != PH_TAG);
  assign more      = item_i.in_byte[7];
  assign too_long  = more && (cnt_q == CntW'(MaxVarintBytes - 1));
  assign bad_wire  = (tag_wire == WIRE_SGROUP) || (tag_wire == WIRE_EGROUP) ||
                     (tag_wire == WIRE_RSVD6) || (tag_wire == WIRE_RSVD7);

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    field_d = field_q;
    wire_d  = wire_q;
    rem_d   = rem_q;
    emit    = 1'b0;
    res     = '0;
    if (take_o) begin
      case (phase_q)
        PH_ERR: begin
          if (item_i.last_byte) begin
            emit     = 1'b1;
            res.kind = KIND_END;
          end
        end
        PH_FIXED: begin
          acc_d = facc;
          cnt_d = vcnt;
          rem_d = rem_dec;
          if (rem_last) begin
            emit            = 1'b1;
            res.kind        = KIND_FIELD;
            res.field_id    = field_q;
            res.wire_code   = wire_q;
            res.field_value = facc;
            acc_d           = '0;
            cnt_d           = '0;
            phase_d         = PH_TAG;
          end else if (item_i.last_byte) begin
            emit            = 1'b1;
            res.kind        = KIND_ERROR;
            res.field_id    = field_q;
            res.wire_code   = wire_q;
            res.error_cause = CAUSE_TRUNCATED;
          end
        end
        PH_PAYLOAD: begin
          rem_d         = rem_dec;
          emit          = 1'b1;
          res.field_id  = field_q;
          res.wire_code = wire_q;
          if (!rem_last && item_i.last_byte) begin
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TRUNCATED;
          end else begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = item_i.in_byte;
            if (rem_last) begin
              phase_d = PH_TAG;
            end
          end
        end
        PH_TAG, PH_VARVAL, PH_LENLEN: begin
          if (too_long) begin
            emit            = 1'b1;
            res.kind        = KIND_ERROR;
            res.error_cause = CAUSE_TOO_LONG;
            if (tag_known) begin
              res.field_id  = field_q;
              res.wire_code = wire_q;
            end
            phase_d = PH_ERR;
          end else if (more) begin
            if (item_i.last_byte) begin
              emit            = 1'b1;
              res.kind        = KIND_ERROR;
              res.error_cause = CAUSE_TRUNCATED;
              if (tag_known) begin
                res.field_id  = field_q;
                res.wire_code = wire_q;
              end
            end else begin
              acc_d = vacc;
              cnt_d = vcnt;
            end
          end else begin
            acc_d = '0;
            cnt_d = '0;
            if (phase_q == PH_TAG) begin
              field_d = tag_field;
              wire_d  = tag_wire;
              if (bad_wire) begin
                emit            = 1'b1;
                res.kind        = KIND_ERROR;
                res.field_id    = tag_field;
                res.wire_code   = tag_wire;
                res.error_cause = CAUSE_BAD_WIRE;
                phase_d         = PH_ERR;
              end else if (item_i.last_byte) begin
                emit            = 1'b1;
                res.kind        = KIND_ERROR;
                res.field_id    = tag_field;
                res.wire_code   = tag_wire;
                res.error_cause = CAUSE_TRUNCATED;
              end else begin
                case (tag_wire)
                  WIRE_VARINT:  phase_d = PH_VARVAL;
                  WIRE_LEN:     phase_d = PH_LENLEN;
                  WIRE_FIXED64: begin
                    phase_d = PH_FIXED;
                    rem_d   = 64'd8;
                  end
                  WIRE_FIXED32: begin
                    phase_d = PH_FIXED;
                    rem_d   = 64'd4;
                  end
                  default: phase_d = PH_ERR;
                endcase
              end
            end else begin
              emit            = 1'b1;
              res.kind        = KIND_FIELD;
              res.field_id    = field_q;
              res.wire_code   = wire_q;
              res.field_value = vacc;
              phase_d         = PH_TAG;
              if ((phase_q == PH_LENLEN) && (vacc != 64'd0)) begin
                if (item_i.last_byte) begin
                  res.kind        = KIND_ERROR;
                  res.field_value = '0;
                  res.error_cause = CAUSE_TRUNCATED;
                end else begin
                  rem_d   = vacc;
                  phase_d = PH_PAYLOAD;
                end
              end
            end
          end
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
      // the last byte always reports and returns the parser to its idle state
      if (item_i.last_byte) begin
        res.msg_end = 1'b1;
        phase_d     = PH_TAG;
        acc_d       = '0;
        cnt_d       = '0;
        field_d     = '0;
        wire_d      = '0;
        rem_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_TAG;
      acc_q   <= '0;
      cnt_q   <= '0;
      field_q <= '0;
      wire_q  <= '0;
      rem_q   <= '0;
    end else begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      field_q <= field_d;
      wire_q  <= wire_d;
      rem_q   <= rem_d;
    end
  end

  assign emit_o   = emit;
  assign result_o = res;

  assign last_take  = take_o && item_i.last_byte;
  assign parse_idle = (phase_q == PH_TAG) && (rem_q == 64'd0) && (acc_q == 64'd0);
  assign err_emit   = emit && (res.kind == KIND_ERROR);

  `PBT_ASSERT(a_last_clears, clk_i, rst_ni, last_take |=> parse_idle)
  `PBT_ASSERT_NEVER(a_err_quiet, clk_i, rst_ni, (phase_q == PH_ERR) && emit && !item_i.last_byte)
  `PBT_ASSERT_NEVER(a_err_has_cause, clk_i, rst_ni, err_emit && (res.error_cause == CAUSE_NONE))
  `PBT_ASSERT(a_fixed_rem, clk_i, rst_ni, (phase_q == PH_FIXED) |-> (rem_q != 0 && rem_q <= 8))

endmodule

// ----- design/pbt_out_stage.sv -----
// Result register of the tokenizer: holds one token until the sink takes it.
// Depends on pbt_pkg.
module pbt_out_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  pbt_pkg::pbt_result_t result_i,
  output logic                 free_o,
  output logic                 valid_o,
  input  logic                 ready_i,
  output pbt_pkg::pbt_result_t result_o
);
  import pbt_pkg::*;

  logic        valid_q, valid_d;
  pbt_result_t data_q;

  // free when empty or when the held token leaves this cycle
  assign free_o = !valid_q || ready_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_i) begin
      valid_d = 1'b0;
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign valid_o  = valid_q;
  assign result_o = data_q;

endmodule

// ----- design/protobuf_wire_field_tokenizer_top.sv -----
// Protobuf wire field tokenizer, top level. Uses pbt_pkg, pbt_in_if, pbt_out_if.
// A byte waits in the input register; its decoded result waits in the result register.
// Throughput: one byte per cycle while the result register is free; state updates once per byte.
// A full result register does not stop input while the sink takes it the same cycle.
// Reset (rst_ni low, asynchronous) empties both registers and parses a new tag.
module protobuf_wire_field_tokenizer_top #(
  parameter int unsigned MaxVarintBytes = pbt_pkg::MAX_VARINT_BYTES
) (
  input  logic clk_i,
  input  logic rst_ni,
  pbt_in_if.sink    in_ch,
  pbt_out_if.source out_ch
);
  import pbt_pkg::*;

  pbt_item_t   in_item, held_item;
  logic        held_valid;
  logic        take;
  logic        emit;
  logic        out_free;
  logic        in_ready;
  logic        out_valid;
  pbt_result_t step_res, out_res;

  assign in_item.in_byte   = in_ch.in_byte;
  assign in_item.last_byte = in_ch.last_byte;
  assign in_ch.ready       = in_ready;

  // Input register: one byte waiting for the decoder.
  pbt_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_ch.valid),
    .ready_o (in_ready),
    .item_i  (in_item),
    .valid_o (held_valid),
    .item_o  (held_item),
    .take_i  (take)
  );

  // Decoder: consume the held byte whenever the result register can take
  // whatever it produces; bytes that produce no token still advance.
  pbt_decode #(
    .MaxVarintBytes (MaxVarintBytes)
  ) u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (held_valid),
    .item_i       (held_item),
    .out_free_i   (out_free),
    .take_o       (take),
    .emit_o       (emit),
    .result_o     (step_res)
  );

  // Result register: hold the token until the sink completes the transfer.
  pbt_out_stage u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (emit),
    .result_i (step_res),
    .free_o   (out_free),
    .valid_o  (out_valid),
    .ready_i  (out_ch.ready),
    .result_o (out_res)
  );

  assign out_ch.valid        = out_valid;
  assign out_ch.kind         = out_res.kind;
  assign out_ch.field_id     = out_res.field_id;
  assign out_ch.wire_code    = out_res.wire_code;
  assign out_ch.field_value  = out_res.field_value;
  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.error_cause  = out_res.error_cause;
  assign out_ch.msg_end      = out_res.msg_end;

endmodule
